[design/chunk_lru_cache_lookup_macros.svh]
// assertion macros shared by the checker of the chunk lru cache lookup block
// expects signals named clock and reset in the scope where a macro is used
`ifndef CHUNK_LRU_CACHE_LOOKUP_MACROS_SVH
`define CHUNK_LRU_CACHE_LOOKUP_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define CLC_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, ignored while reset is high
`define CLC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/clc_pkg.sv]
// shared types and constants of the chunk lru cache lookup block
// no dependencies
package clc_pkg;

   localparam int ENTRIES_DEFAULT    = 16;
   localparam int INDEX_BITS_DEFAULT = 32;

   localparam int SAMPLE_W     = 32;
   localparam int CHUNK_W      = 32;
   localparam int OFFSET_W     = 16;
   localparam int SLOT_OUT_W   = 4;
   localparam int COUNT_W      = 32;
   localparam int CHUNK_LEN_W  = 16;
   localparam int CAPACITY_W   = 5;
   localparam int CSR_DATA_W   = 16;
   localparam int CSR_INDEX_W  = 1;

   localparam logic [CHUNK_LEN_W-1:0] CHUNK_LEN_RESET = 16'd64;
   localparam logic [CAPACITY_W-1:0]  CAPACITY_RESET  = 5'd16;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHUNK_LEN = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPACITY  = 1'b1;

   localparam logic ACT_LOOKUP = 1'b0;
   localparam logic ACT_CLEAR  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SCAN,
      ST_DRAIN,
      ST_UPDATE,
      ST_EVICT
   } state_type;

endpackage

[design/chunk_lru_cache_lookup.sv]
// chunk lru cache lookup: serial divider, tag store scan and lru bookkeeping
// depends on clc_pkg
//
// usage: pulse start with req_action and req_sample_index while busy is low.
// a lookup divides the index by the chunk length register one quotient bit per
// cycle, then scans the tag memory one entry per cycle through its single read
// port, then updates recency ranks and installs the chunk on a miss.
// busy stays high through the divide, scan, drain and update states, and
// through an evict state as well when a miss evicts; the divider takes the
// low INDEX_BITS bits of the index, capped at 32. the result strobe rsp_valid
// is high for one cycle, the first cycle after busy falls, and a new start
// may be taken in that same cycle.
// a clear is done at once: busy stays low and the all-zero result is strobed
// on the next cycle. the receiver cannot stall: each result shows for one
// cycle only. csr writes are taken on any cycle with csr_we high; writing the
// capacity register empties the store. reset restores chunk length 64,
// capacity 16, an empty store and zero counters.
module chunk_lru_cache_lookup
   import clc_pkg::*;
#(
   parameter int ENTRIES    = ENTRIES_DEFAULT,
   parameter int INDEX_BITS = INDEX_BITS_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_action,
   input  logic [SAMPLE_W-1:0]     req_sample_index,
   output logic                    rsp_valid,
   output logic [CHUNK_W-1:0]      rsp_chunk_number,
   output logic [OFFSET_W-1:0]     rsp_offset_in_chunk,
   output logic                    rsp_hit,
   output logic [SLOT_OUT_W-1:0]   rsp_slot,
   output logic                    rsp_evicted_valid,
   output logic [CHUNK_W-1:0]      rsp_evicted_chunk,
   output logic [COUNT_W-1:0]      rsp_hit_total,
   output logic [COUNT_W-1:0]      rsp_miss_total,
   input  logic                    csr_we,
   input  logic [CSR_INDEX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
);

   localparam int IDX_W  = (INDEX_BITS < SAMPLE_W) ? INDEX_BITS : SAMPLE_W;
   localparam int STEP_W = $clog2(IDX_W);
   localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RANK_W = SLOT_W;
   localparam int OCC_W  = $clog2(ENTRIES + 1);
   localparam int CMP_W  = (OCC_W > CAPACITY_W) ? OCC_W : CAPACITY_W;
   localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(ENTRIES - 1);

   state_type state_ff, state_in;

   logic [CHUNK_LEN_W-1:0]  chunk_len_ff, chunk_len_in;
   logic [CAPACITY_W-1:0]   capacity_ff, capacity_in;

   logic [IDX_W-1:0]        quot_ff, quot_in;
   logic [CHUNK_LEN_W-1:0]  rem_ff, rem_in;
   logic [CHUNK_LEN_W-1:0]  divisor_ff, divisor_in;
   logic [STEP_W-1:0]       step_ff, step_in;

   logic [SLOT_W-1:0]       scan_ff, scan_in;
   logic [SLOT_W-1:0]       rd_idx_ff, rd_idx_in;
   logic                    cmp_vld_ff, cmp_vld_in;
   logic                    found_ff, found_in;
   logic [SLOT_W-1:0]       found_idx_ff, found_idx_in;
   logic [SLOT_W-1:0]       victim_ff, victim_in;
   logic [CHUNK_W-1:0]      rd_tag_ff;

   logic [ENTRIES-1:0]      valid_ff, valid_in;
   logic [RANK_W-1:0]       rank_ff [ENTRIES];
   logic [RANK_W-1:0]       rank_in [ENTRIES];
   logic [OCC_W-1:0]        occ_ff, occ_in;
   logic [COUNT_W-1:0]      hit_cnt_ff, hit_cnt_in;
   logic [COUNT_W-1:0]      miss_cnt_ff, miss_cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CHUNK_W-1:0]      rsp_chunk_ff, rsp_chunk_in;
   logic [OFFSET_W-1:0]     rsp_offset_ff, rsp_offset_in;
   logic                    rsp_hit_ff, rsp_hit_in;
   logic [SLOT_OUT_W-1:0]   rsp_slot_ff, rsp_slot_in;
   logic                    rsp_ev_valid_ff, rsp_ev_valid_in;
   logic [CHUNK_W-1:0]      rsp_ev_chunk_ff, rsp_ev_chunk_in;
   logic [COUNT_W-1:0]      rsp_hit_tot_ff, rsp_hit_tot_in;
   logic [COUNT_W-1:0]      rsp_miss_tot_ff, rsp_miss_tot_in;

   logic [CHUNK_W-1:0]      tag_mem [ENTRIES];
   logic                    mem_we;
   logic [SLOT_W-1:0]       mem_waddr;
   logic [SLOT_W-1:0]       mem_raddr;

   logic                    accept;
   logic                    store_clear;
   logic [CHUNK_LEN_W:0]    rem_shift;
   logic [CHUNK_LEN_W:0]    rem_diff;
   logic                    sub_ok;
   logic [CHUNK_W-1:0]      chunk_val;
   logic                    tag_match;
   logic [CMP_W-1:0]        cap_lim;
   logic                    full;
   logic [SLOT_W-1:0]       victim_sel;
   logic [ENTRIES-1:0]      avail_mask;
   logic [SLOT_W-1:0]       free_slot;
   logic [RANK_W-1:0]       hit_rank;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // restoring divider step
   assign rem_shift = {rem_ff, quot_ff[IDX_W-1]};
   assign rem_diff  = rem_shift - {1'b0, divisor_ff};
   assign sub_ok    = (rem_shift >= {1'b0, divisor_ff});
   assign chunk_val = CHUNK_W'(quot_ff);

   assign tag_match = cmp_vld_ff && valid_ff[rd_idx_ff] && (rd_tag_ff == chunk_val);
   assign hit_rank  = rank_ff[found_idx_ff];

   always_comb begin
      cap_lim = (capacity_ff == '0) ? CMP_W'(1) : CMP_W'(capacity_ff);
      if (cap_lim > CMP_W'(ENTRIES)) begin
         cap_lim = CMP_W'(ENTRIES);
      end
      full = (CMP_W'(occ_ff) >= cap_lim);
   end

   // ranks of valid entries are a permutation of 0..occ-1, so the lru entry
   // is the one whose rank is occ-1
   always_comb begin
      victim_sel = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (OCC_W'(rank_ff[i]) == (occ_ff - OCC_W'(1)))) begin
            victim_sel = SLOT_W'(i);
         end
      end
   end

   // lowest empty slot, counting the victim as gone in the evict state
   always_comb begin
      avail_mask = valid_ff;
      if (state_ff == ST_EVICT) begin
         avail_mask[victim_ff] = 1'b0;
      end
      free_slot = '0;
      for (int i = ENTRIES - 1; i >= 0; i--) begin
         if (!avail_mask[i]) begin
            free_slot = SLOT_W'(i);
         end
      end
   end

   always_comb begin
      state_in        = state_ff;
      chunk_len_in    = chunk_len_ff;
      capacity_in     = capacity_ff;
      quot_in         = quot_ff;
      rem_in          = rem_ff;
      divisor_in      = divisor_ff;
      step_in         = step_ff;
      scan_in         = scan_ff;
      rd_idx_in       = rd_idx_ff;
      cmp_vld_in      = 1'b0;
      found_in        = found_ff;
      found_idx_in    = found_idx_ff;
      victim_in       = victim_ff;
      valid_in        = valid_ff;
      rank_in         = rank_ff;
      occ_in          = occ_ff;
      hit_cnt_in      = hit_cnt_ff;
      miss_cnt_in     = miss_cnt_ff;
      rsp_valid_in    = 1'b0;
      rsp_chunk_in    = rsp_chunk_ff;
      rsp_offset_in   = rsp_offset_ff;
      rsp_hit_in      = rsp_hit_ff;
      rsp_slot_in     = rsp_slot_ff;
      rsp_ev_valid_in = rsp_ev_valid_ff;
      rsp_ev_chunk_in = rsp_ev_chunk_ff;
      rsp_hit_tot_in  = rsp_hit_tot_ff;
      rsp_miss_tot_in = rsp_miss_tot_ff;
      mem_we          = 1'b0;
      mem_waddr       = free_slot;
      mem_raddr       = scan_ff;
      store_clear     = 1'b0;

      if (tag_match && !found_ff) begin
         found_in     = 1'b1;
         found_idx_in = rd_idx_ff;
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_action == ACT_CLEAR) begin
                  store_clear     = 1'b1;
                  hit_cnt_in      = '0;
                  miss_cnt_in     = '0;
                  rsp_valid_in    = 1'b1;
                  rsp_chunk_in    = '0;
                  rsp_offset_in   = '0;
                  rsp_hit_in      = 1'b0;
                  rsp_slot_in     = '0;
                  rsp_ev_valid_in = 1'b0;
                  rsp_ev_chunk_in = '0;
                  rsp_hit_tot_in  = '0;
                  rsp_miss_tot_in = '0;
               end else begin
                  state_in   = ST_DIVIDE;
                  quot_in    = req_sample_index[IDX_W-1:0];
                  rem_in     = '0;
                  divisor_in = (chunk_len_ff == '0) ? CHUNK_LEN_W'(1) : chunk_len_ff;
                  step_in    = STEP_W'(IDX_W - 1);
                  found_in   = 1'b0;
               end
            end
         end
         ST_DIVIDE: begin
            rem_in  = sub_ok ? rem_diff[CHUNK_LEN_W-1:0] : rem_shift[CHUNK_LEN_W-1:0];
            quot_in = {quot_ff[IDX_W-2:0], sub_ok};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               state_in = ST_SCAN;
               scan_in  = '0;
            end
         end
         ST_SCAN: begin
            mem_raddr  = scan_ff;
            rd_idx_in  = scan_ff;
            cmp_vld_in = 1'b1;
            if (scan_ff == LAST_SLOT) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + SLOT_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            rsp_chunk_in  = chunk_val;
            rsp_offset_in = rem_ff;
            if (found_ff) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (valid_ff[i] && (rank_ff[i] < hit_rank)) begin
                     rank_in[i] = rank_ff[i] + RANK_W'(1);
                  end
               end
               rank_in[found_idx_ff] = '0;
               hit_cnt_in      = hit_cnt_ff + COUNT_W'(1);
               state_in        = ST_IDLE;
               rsp_valid_in    = 1'b1;
               rsp_hit_in      = 1'b1;
               rsp_slot_in     = SLOT_OUT_W'(found_idx_ff);
               rsp_ev_valid_in = 1'b0;
               rsp_ev_chunk_in = '0;
               rsp_hit_tot_in  = hit_cnt_ff + COUNT_W'(1);
               rsp_miss_tot_in = miss_cnt_ff;
            end else begin
               miss_cnt_in = miss_cnt_ff + COUNT_W'(1);
               if (full) begin
                  // fetch the victim tag, install on the next cycle
                  mem_raddr = victim_sel;
                  victim_in = victim_sel;
                  state_in  = ST_EVICT;
               end else begin
                  for (int i = 0; i < ENTRIES; i++) begin
                     if (valid_ff[i]) begin
                        rank_in[i] = rank_ff[i] + RANK_W'(1);
                     end
                  end
                  rank_in[free_slot]  = '0;
                  valid_in[free_slot] = 1'b1;
                  occ_in              = occ_ff + OCC_W'(1);
                  mem_we              = 1'b1;
                  state_in            = ST_IDLE;
                  rsp_valid_in        = 1'b1;
                  rsp_hit_in          = 1'b0;
                  rsp_slot_in         = SLOT_OUT_W'(free_slot);
                  rsp_ev_valid_in     = 1'b0;
                  rsp_ev_chunk_in     = '0;
                  rsp_hit_tot_in      = hit_cnt_ff;
                  rsp_miss_tot_in     = miss_cnt_ff + COUNT_W'(1);
               end
            end
         end
         ST_EVICT: begin
            rank_in[victim_ff] = '0;
            for (int i = 0; i < ENTRIES; i++) begin
               if (avail_mask[i]) begin
                  rank_in[i] = rank_ff[i] + RANK_W'(1);
               end
            end
            valid_in            = avail_mask;
            rank_in[free_slot]  = '0;
            valid_in[free_slot] = 1'b1;
            mem_we              = 1'b1;
            state_in            = ST_IDLE;
            rsp_valid_in        = 1'b1;
            rsp_hit_in          = 1'b0;
            rsp_slot_in         = SLOT_OUT_W'(free_slot);
            rsp_ev_valid_in     = 1'b1;
            rsp_ev_chunk_in     = rd_tag_ff;
            rsp_hit_tot_in      = hit_cnt_ff;
            rsp_miss_tot_in     = miss_cnt_ff;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (csr_we) begin
         case (csr_index)
            CSR_CHUNK_LEN: chunk_len_in = csr_wdata[CHUNK_LEN_W-1:0];
            CSR_CAPACITY: begin
               capacity_in = csr_wdata[CAPACITY_W-1:0];
               store_clear = 1'b1;
            end
            default: ;
         endcase
      end

      if (store_clear) begin
         valid_in = '0;
         occ_in   = '0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_len_ff  <= CHUNK_LEN_RESET;
         capacity_ff   <= CAPACITY_RESET;
         cmp_vld_ff    <= 1'b0;
         found_ff      <= 1'b0;
         valid_ff      <= '0;
         occ_ff        <= '0;
         hit_cnt_ff    <= '0;
         miss_cnt_ff   <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < ENTRIES; i++) begin
            rank_ff[i] <= '0;
         end
      end else begin
         chunk_len_ff  <= chunk_len_in;
         capacity_ff   <= capacity_in;
         cmp_vld_ff    <= cmp_vld_in;
         found_ff      <= found_in;
         valid_ff      <= valid_in;
         occ_ff        <= occ_in;
         hit_cnt_ff    <= hit_cnt_in;
         miss_cnt_ff   <= miss_cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
         rank_ff       <= rank_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff         <= quot_in;
      rem_ff          <= rem_in;
      divisor_ff      <= divisor_in;
      step_ff         <= step_in;
      scan_ff         <= scan_in;
      rd_idx_ff       <= rd_idx_in;
      found_idx_ff    <= found_idx_in;
      victim_ff       <= victim_in;
      rsp_chunk_ff    <= rsp_chunk_in;
      rsp_offset_ff   <= rsp_offset_in;
      rsp_hit_ff      <= rsp_hit_in;
      rsp_slot_ff     <= rsp_slot_in;
      rsp_ev_valid_ff <= rsp_ev_valid_in;
      rsp_ev_chunk_ff <= rsp_ev_chunk_in;
      rsp_hit_tot_ff  <= rsp_hit_tot_in;
      rsp_miss_tot_ff <= rsp_miss_tot_in;
   end

   // tag memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         tag_mem[mem_waddr] <= chunk_val;
      end
   end

   always_ff @(posedge clock) begin
      rd_tag_ff <= tag_mem[mem_raddr];
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_chunk_number    = rsp_chunk_ff;
   assign rsp_offset_in_chunk = rsp_offset_ff;
   assign rsp_hit             = rsp_hit_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_evicted_valid   = rsp_ev_valid_ff;
   assign rsp_evicted_chunk   = rsp_ev_chunk_ff;
   assign rsp_hit_total       = rsp_hit_tot_ff;
   assign rsp_miss_total      = rsp_miss_tot_ff;

endmodule

[design/clc_checker.sv]
// port-level checker for the chunk lru cache lookup block, bound to the top level
// depends on clc_pkg and chunk_lru_cache_lookup_macros.svh
`include "chunk_lru_cache_lookup_macros.svh"

module clc_checker
   import clc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   req_action,
   input logic                   rsp_valid,
   input logic                   rsp_hit,
   input logic                   rsp_evicted_valid,
   input logic [CHUNK_W-1:0]     rsp_evicted_chunk,
   input logic [COUNT_W-1:0]     rsp_hit_total,
   input logic [COUNT_W-1:0]     rsp_miss_total
);

   // a result only shows once the sequencer is back at rest
   `CLC_ASSERT_NOW(a_rsp_when_idle, rsp_valid, !busy, "result strobe while busy")

   // a lookup transaction always occupies the sequencer
   `CLC_ASSERT_NEXT(a_lookup_busy, start && !busy && (req_action == ACT_LOOKUP), busy, "lookup did not raise busy")

   // a clear transaction answers on the next cycle with zeroed counters
   `CLC_ASSERT_NEXT(a_clear_rsp, start && !busy && (req_action == ACT_CLEAR), rsp_valid && !rsp_hit && (rsp_hit_total == '0) && (rsp_miss_total == '0), "clear result wrong")

   // a hit never evicts, and no eviction means no evicted chunk
   `CLC_ASSERT_NOW(a_hit_no_evict, rsp_valid && rsp_hit, !rsp_evicted_valid, "hit reported an eviction")

   `CLC_ASSERT_NOW(a_evict_zero, rsp_valid && !rsp_evicted_valid, rsp_evicted_chunk == '0, "evicted chunk without eviction")

endmodule

bind chunk_lru_cache_lookup clc_checker u_clc_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_action        (req_action),
   .rsp_valid         (rsp_valid),
   .rsp_hit           (rsp_hit),
   .rsp_evicted_valid (rsp_evicted_valid),
   .rsp_evicted_chunk (rsp_evicted_chunk),
   .rsp_hit_total     (rsp_hit_total),
   .rsp_miss_total    (rsp_miss_total)
);
